@@ sv/sfir_pkg.sv @@
// Shared constants, types and functions of the symmetric FIR filter unit.
`timescale 1ns / 1ps

package sfir_pkg;

    localparam int DELAY_DEPTH = 256;
    localparam int MAX_TAPS    = 255;
    localparam int POS_W       = $clog2(DELAY_DEPTH);
    localparam int COEF_DEPTH  = MAX_TAPS / 2 + 1;
    localparam int CIDX_W      = 7;
    localparam int MAX_LEN     = (MAX_TAPS < DELAY_DEPTH - 1) ? MAX_TAPS : DELAY_DEPTH - 1;

    localparam int LEN_W      = 8;
    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 18;
    localparam int REWIND_W   = 8;
    localparam int SUM_W      = SAMPLE_W + 1;
    localparam int PROD_W     = SUM_W + COEF_W;
    localparam int ACC_W      = PROD_W + CIDX_W + 2;
    localparam int RND_SHIFT  = 17;
    localparam int Q_W        = ACC_W - RND_SHIFT;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [OP_W-1:0] OP_FILT   = 2'd0;
    localparam logic [OP_W-1:0] OP_WCOEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_REWIND = 2'd3;

    typedef struct packed {
        logic vld;
        logic ctr;
    } t_mac_ctl;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] tap_len);
        logic [LEN_W-1:0] len;
        len = (tap_len == '0) ? LEN_W'(1) : tap_len;
        if (len > LEN_W'(MAX_LEN)) begin
            len = LEN_W'(MAX_LEN);
        end
        return len;
    endfunction

endpackage

@@ sv/sfir_dline.sv @@
// Circular sample delay line: one write port, two registered read ports, valid bits.
`timescale 1ns / 1ps

module sfir_dline (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_we,
    input  logic [sfir_pkg::POS_W-1:0]             i_waddr,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]   i_wdata,
    input  logic                                   i_clr,
    input  logic [sfir_pkg::POS_W-1:0]             i_addr_a,
    input  logic [sfir_pkg::POS_W-1:0]             i_addr_b,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]   o_rd_a,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]   o_rd_b
);

    logic signed [sfir_pkg::SAMPLE_W-1:0] r_mem [sfir_pkg::DELAY_DEPTH];
    logic [sfir_pkg::DELAY_DEPTH-1:0]     r_vld;
    logic signed [sfir_pkg::SAMPLE_W-1:0] r_da;
    logic signed [sfir_pkg::SAMPLE_W-1:0] r_db;
    logic                                 r_va;
    logic                                 r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_da <= r_mem[i_addr_a];
        r_db <= r_mem[i_addr_b];
    end

    // valid bits: entry not written since reset or clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_va <= r_vld[i_addr_a];
            r_vb <= r_vld[i_addr_b];
        end
    end

    assign o_rd_a = r_va ? r_da : '0;
    assign o_rd_b = r_vb ? r_db : '0;

endmodule

@@ sv/sfir_coef.sv @@
// Coefficient store: one write port, one registered read port.
`timescale 1ns / 1ps

module sfir_coef (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [sfir_pkg::CIDX_W-1:0]          i_waddr,
    input  logic signed [sfir_pkg::COEF_W-1:0]   i_wdata,
    input  logic [sfir_pkg::CIDX_W-1:0]          i_raddr,
    output logic signed [sfir_pkg::COEF_W-1:0]   o_rdata
);

    logic signed [sfir_pkg::COEF_W-1:0] r_mem [sfir_pkg::COEF_DEPTH];
    logic signed [sfir_pkg::COEF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sfir_mac.sv @@
// Shared pre-add multiply-accumulate unit, one tap pair per cycle.
`timescale 1ns / 1ps

module sfir_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sfir_pkg::t_mac_ctl                   i_ctl,
    input  logic                                 i_clr,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] i_rd_a,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] i_rd_b,
    input  logic signed [sfir_pkg::COEF_W-1:0]   i_coef,
    output logic signed [sfir_pkg::ACC_W-1:0]    o_acc,
    output logic                                 o_done
);

    sfir_pkg::t_mac_ctl                 r_c1;
    sfir_pkg::t_mac_ctl                 r_c2;
    sfir_pkg::t_mac_ctl                 r_c3;
    logic                               r_done;
    logic signed [sfir_pkg::SAMPLE_W-1:0] w_b;
    logic signed [sfir_pkg::SUM_W-1:0]  n_sum;
    logic signed [sfir_pkg::SUM_W-1:0]  r_sum;
    logic signed [sfir_pkg::COEF_W-1:0] r_cf;
    logic signed [sfir_pkg::PROD_W-1:0] r_prod;
    logic signed [sfir_pkg::ACC_W-1:0]  r_acc;

    // center tap has no partner sample
    assign w_b   = r_c1.ctr ? '0 : i_rd_b;
    assign n_sum = sfir_pkg::SUM_W'(i_rd_a) + sfir_pkg::SUM_W'(w_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctl;
            r_c2   <= r_c1;
            r_c3   <= r_c2;
            r_done <= r_c3.vld && r_c3.ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_cf   <= i_coef;
        r_prod <= r_sum * r_cf;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_c3.vld) begin
            r_acc <= r_acc + sfir_pkg::ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

@@ sv/sfir_ctrl.sv @@
// Sequencer: op decode, tap addressing, write position, rounding and output word.
`timescale 1ns / 1ps

module sfir_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sfir_pkg::LEN_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [sfir_pkg::OP_W-1:0]              i_op,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  logic [sfir_pkg::CIDX_W-1:0]            i_coef_index,
    input  logic signed [sfir_pkg::COEF_W-1:0]     i_coef_value,
    input  logic [sfir_pkg::REWIND_W-1:0]          i_rewind_count,
    input  logic                                   i_block_last_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                   o_saturated,
    output logic                                   o_block_last_out,
    output logic                                   o_dl_we,
    output logic [sfir_pkg::POS_W-1:0]             o_dl_waddr,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]   o_dl_wdata,
    output logic                                   o_dl_clr,
    output logic [sfir_pkg::POS_W-1:0]             o_dl_addr_a,
    output logic [sfir_pkg::POS_W-1:0]             o_dl_addr_b,
    output logic                                   o_cf_we,
    output logic [sfir_pkg::CIDX_W-1:0]            o_cf_waddr,
    output logic signed [sfir_pkg::COEF_W-1:0]     o_cf_wdata,
    output logic [sfir_pkg::CIDX_W-1:0]            o_cf_raddr,
    output sfir_pkg::t_mac_ctl                     o_mac_ctl,
    output logic                                   o_mac_clr,
    input  logic                                   i_mac_done,
    input  logic signed [sfir_pkg::ACC_W-1:0]      i_acc
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [sfir_pkg::LEN_W-1:0]        r_tap_length;
    logic [sfir_pkg::LEN_W-1:0]        r_len;
    logic [sfir_pkg::LEN_W-1:0]        w_len;
    logic [sfir_pkg::CIDX_W-1:0]       r_half;
    logic [sfir_pkg::CIDX_W-1:0]       r_j;
    logic [sfir_pkg::POS_W-1:0]        r_pos;
    logic                              r_last;
    logic                              w_acc;
    logic                              w_load;
    logic                              w_ctr;
    logic signed [sfir_pkg::ACC_W-1:0] w_rnd;
    logic signed [sfir_pkg::Q_W-1:0]   w_q;
    logic                              w_hi;
    logic                              w_lo;
    logic signed [sfir_pkg::SAMPLE_W-1:0] w_res;
    logic                              r_out_valid;
    logic signed [sfir_pkg::SAMPLE_W-1:0] r_sample_out;
    logic                              r_saturated;
    logic                              r_block_last_out;

    assign w_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_len  = sfir_pkg::eff_len(r_tap_length);
    assign w_ctr  = (r_j == r_half);
    assign w_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign o_in_stall = (r_state != S_IDLE);

    // delay line and coefficient store
    assign o_dl_we     = w_acc && (i_op == sfir_pkg::OP_FILT);
    assign o_dl_waddr  = r_pos;
    assign o_dl_wdata  = i_sample_in;
    assign o_dl_clr    = w_acc && (i_op == sfir_pkg::OP_CLEAR);
    assign o_dl_addr_a = r_pos - sfir_pkg::POS_W'(r_j);
    assign o_dl_addr_b = r_pos - sfir_pkg::POS_W'(r_len - 1'b1) + sfir_pkg::POS_W'(r_j);
    assign o_cf_we     = w_acc && (i_op == sfir_pkg::OP_WCOEF) &&
                         ((sfir_pkg::CIDX_W + 1)'(i_coef_index) <
                          (sfir_pkg::CIDX_W + 1)'(sfir_pkg::COEF_DEPTH));
    assign o_cf_waddr  = i_coef_index;
    assign o_cf_wdata  = i_coef_value;
    assign o_cf_raddr  = r_j;
    assign o_mac_ctl.vld = (r_state == S_RUN);
    assign o_mac_ctl.ctr = w_ctr;
    assign o_mac_clr   = o_dl_we;

    // round half up, then clip to the sample range
    assign w_rnd = i_acc + sfir_pkg::RND_HALF;
    assign w_q   = signed'(w_rnd[sfir_pkg::ACC_W-1:sfir_pkg::RND_SHIFT]);
    assign w_hi  = !w_q[sfir_pkg::Q_W-1] && (|w_q[sfir_pkg::Q_W-2:sfir_pkg::SAMPLE_W-1]);
    assign w_lo  = w_q[sfir_pkg::Q_W-1] && !(&w_q[sfir_pkg::Q_W-2:sfir_pkg::SAMPLE_W-1]);
    assign w_res = w_hi ? sfir_pkg::SAMPLE_MAX :
                   w_lo ? sfir_pkg::SAMPLE_MIN : w_q[sfir_pkg::SAMPLE_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_op == sfir_pkg::OP_FILT)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_ctr) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_mac_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tap_length <= sfir_pkg::LEN_W'(1);
            r_pos        <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tap_length <= i_cfg_data;
            end
            if (w_acc) begin
                unique case (i_op)
                    sfir_pkg::OP_FILT:   r_j <= '0;
                    sfir_pkg::OP_WCOEF:  r_j <= '0;
                    sfir_pkg::OP_CLEAR:  r_pos <= '0;
                    sfir_pkg::OP_REWIND: r_pos <= r_pos - sfir_pkg::POS_W'(i_rewind_count);
                    default:             r_j <= '0;
                endcase
            end else if ((r_state == S_RUN) && !w_ctr) begin
                r_j <= r_j + 1'b1;
            end else if (w_load) begin
                r_pos <= r_pos + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_len  <= w_len;
            r_half <= sfir_pkg::CIDX_W'((w_len - 1'b1) >> 1);
            r_last <= i_block_last_in;
        end
        if (w_load) begin
            r_sample_out     <= w_res;
            r_saturated      <= w_hi || w_lo;
            r_block_last_out <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = r_sample_out;
    assign o_saturated      = r_saturated;
    assign o_block_last_out = r_block_last_out;

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("output word raised outside finish step");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mac_done |-> r_state == S_WAIT)
        else $error("accumulator finished outside wait step");

    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_j <= r_half)
        else $error("tap counter ran past center");

    a_pos_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_pos != $past(r_pos)) |->
            ($past(r_state) == S_FIN) || ($past(r_state) == S_IDLE))
        else $error("write position moved during filtering");
`endif

endmodule

@@ sv/symmetric_fir_filter_unit.sv @@
// Top level of the symmetric FIR filter unit.
//
//  channel  dir  handshake                  word
//  -------  ---  -------------------------  ------------------------------------------
//  input    in   i_in_valid / o_in_stall    op, sample, coef index/value, rewind, last
//  output   out  o_out_valid / i_out_stall  sample, saturated flag, last
//  config   in   i_cfg_we                   tap_length
//
//  Filter word: accept step, tap pairs from the outer pair in to the center tap,
//  pipeline drain, round step; all pairs share the single pre-add multiplier.
//  Coefficient write, clear and rewind words end in the accept step and give no output word.
//  Reset clears the delay line through per-entry valid bits at once; no sweep.
//  A stalled output word holds; a new word is taken meanwhile, a filter result waits.
`timescale 1ns / 1ps

module symmetric_fir_filter_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sfir_pkg::LEN_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [sfir_pkg::OP_W-1:0]              i_op,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  logic [sfir_pkg::CIDX_W-1:0]            i_coef_index,
    input  logic signed [sfir_pkg::COEF_W-1:0]     i_coef_value,
    input  logic [sfir_pkg::REWIND_W-1:0]          i_rewind_count,
    input  logic                                   i_block_last_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                   o_saturated,
    output logic                                   o_block_last_out
);

    logic                                 w_dl_we;
    logic [sfir_pkg::POS_W-1:0]           w_dl_waddr;
    logic signed [sfir_pkg::SAMPLE_W-1:0] w_dl_wdata;
    logic                                 w_dl_clr;
    logic [sfir_pkg::POS_W-1:0]           w_dl_addr_a;
    logic [sfir_pkg::POS_W-1:0]           w_dl_addr_b;
    logic signed [sfir_pkg::SAMPLE_W-1:0] w_rd_a;
    logic signed [sfir_pkg::SAMPLE_W-1:0] w_rd_b;
    logic                                 w_cf_we;
    logic [sfir_pkg::CIDX_W-1:0]          w_cf_waddr;
    logic signed [sfir_pkg::COEF_W-1:0]   w_cf_wdata;
    logic [sfir_pkg::CIDX_W-1:0]          w_cf_raddr;
    logic signed [sfir_pkg::COEF_W-1:0]   w_coef;
    sfir_pkg::t_mac_ctl                   w_mac_ctl;
    logic                                 w_mac_clr;
    logic                                 w_mac_done;
    logic signed [sfir_pkg::ACC_W-1:0]    w_acc;

    sfir_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_sample_in      (i_sample_in),
        .i_coef_index     (i_coef_index),
        .i_coef_value     (i_coef_value),
        .i_rewind_count   (i_rewind_count),
        .i_block_last_in  (i_block_last_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sample_out     (o_sample_out),
        .o_saturated      (o_saturated),
        .o_block_last_out (o_block_last_out),
        .o_dl_we          (w_dl_we),
        .o_dl_waddr       (w_dl_waddr),
        .o_dl_wdata       (w_dl_wdata),
        .o_dl_clr         (w_dl_clr),
        .o_dl_addr_a      (w_dl_addr_a),
        .o_dl_addr_b      (w_dl_addr_b),
        .o_cf_we          (w_cf_we),
        .o_cf_waddr       (w_cf_waddr),
        .o_cf_wdata       (w_cf_wdata),
        .o_cf_raddr       (w_cf_raddr),
        .o_mac_ctl        (w_mac_ctl),
        .o_mac_clr        (w_mac_clr),
        .i_mac_done       (w_mac_done),
        .i_acc            (w_acc)
    );

    sfir_dline u_dline (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_dl_we),
        .i_waddr  (w_dl_waddr),
        .i_wdata  (w_dl_wdata),
        .i_clr    (w_dl_clr),
        .i_addr_a (w_dl_addr_a),
        .i_addr_b (w_dl_addr_b),
        .o_rd_a   (w_rd_a),
        .o_rd_b   (w_rd_b)
    );

    sfir_coef u_coef (
        .i_clk   (i_clk),
        .i_we    (w_cf_we),
        .i_waddr (w_cf_waddr),
        .i_wdata (w_cf_wdata),
        .i_raddr (w_cf_raddr),
        .o_rdata (w_coef)
    );

    sfir_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_clr   (w_mac_clr),
        .i_rd_a  (w_rd_a),
        .i_rd_b  (w_rd_b),
        .i_coef  (w_coef),
        .o_acc   (w_acc),
        .o_done  (w_mac_done)
    );

endmodule

@@ bench/tb.sv @@
// Testbench for symmetric_fir_filter_unit: directed and random words against a filter model.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT       = 1_000_000;
    localparam int IDLE_WAIT   = 150;
    localparam int HOLD_CYCLES = 1500;
    localparam int RAND_WORDS  = 470;

    typedef struct {
        logic signed [sfir_pkg::SAMPLE_W-1:0] smp;
        logic                                 sat;
        logic                                 last;
    } t_filt_word;

    logic                                 clk;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [sfir_pkg::LEN_W-1:0]           cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [sfir_pkg::OP_W-1:0]            op = sfir_pkg::OP_FILT;
    logic signed [sfir_pkg::SAMPLE_W-1:0] sample_in = '0;
    logic [sfir_pkg::CIDX_W-1:0]          coef_index = '0;
    logic signed [sfir_pkg::COEF_W-1:0]   coef_value = '0;
    logic [sfir_pkg::REWIND_W-1:0]        rewind_count = '0;
    logic                                 block_last_in = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [sfir_pkg::SAMPLE_W-1:0] sample_out;
    logic                                 saturated;
    logic                                 block_last_out;

    // filter state copy
    logic signed [sfir_pkg::SAMPLE_W-1:0] dline [sfir_pkg::DELAY_DEPTH];
    logic signed [sfir_pkg::COEF_W-1:0]   coef_mem [sfir_pkg::COEF_DEPTH];
    logic [sfir_pkg::POS_W-1:0]           wr_pos;
    logic [sfir_pkg::LEN_W-1:0]           tap_len;

    t_filt_word filtered_q [$];
    int         errors = 0;
    int         cycle_count = 0;
    int         hold_req = 0;
    bit         tx_burst = 1'b0;
    bit         rx_burst = 1'b0;

    symmetric_fir_filter_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_op             (op),
        .i_sample_in      (sample_in),
        .i_coef_index     (coef_index),
        .i_coef_value     (coef_value),
        .i_rewind_count   (rewind_count),
        .i_block_last_in  (block_last_in),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_sample_out     (sample_out),
        .o_saturated      (saturated),
        .o_block_last_out (block_last_out)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // Applies one accepted word to the filter state; queues the filtered sample for op 0.
    function automatic void fir_apply(input logic [sfir_pkg::OP_W-1:0] w_op,
                                      input logic signed [sfir_pkg::SAMPLE_W-1:0] w_smp,
                                      input logic [sfir_pkg::CIDX_W-1:0] w_idx,
                                      input logic signed [sfir_pkg::COEF_W-1:0] w_cv,
                                      input logic [sfir_pkg::REWIND_W-1:0] w_rw,
                                      input logic w_last);
        logic [sfir_pkg::LEN_W-1:0] len;
        logic [sfir_pkg::LEN_W-1:0] half;
        logic [sfir_pkg::LEN_W-1:0] k;
        logic [sfir_pkg::POS_W-1:0] pos;
        longint                     a;
        longint                     b;
        longint                     acc;
        longint                     q;
        t_filt_word                 w;
        case (w_op)
            sfir_pkg::OP_WCOEF: begin
                coef_mem[w_idx] = w_cv;
            end
            sfir_pkg::OP_CLEAR: begin
                foreach (dline[i]) dline[i] = '0;
                wr_pos = '0;
            end
            sfir_pkg::OP_REWIND: begin
                wr_pos = wr_pos - sfir_pkg::POS_W'(w_rw);
            end
            default: begin
                len = (tap_len == '0) ? sfir_pkg::LEN_W'(1) : tap_len;
                if (len > sfir_pkg::LEN_W'(sfir_pkg::MAX_LEN)) begin
                    len = sfir_pkg::LEN_W'(sfir_pkg::MAX_LEN);
                end
                half = (len - 1'b1) >> 1;
                pos = wr_pos;
                dline[pos] = w_smp;
                acc = 0;
                for (k = 0; k < half; k++) begin
                    a = longint'(dline[sfir_pkg::POS_W'(pos - k)]);
                    b = longint'(dline[sfir_pkg::POS_W'(pos - len + 1'b1 + k)]);
                    acc += (a + b) * longint'(coef_mem[k]);
                end
                acc += longint'(dline[sfir_pkg::POS_W'(pos - half)]) *
                       longint'(coef_mem[half]);
                q = (acc + 64'sd65536) >>> 17;
                w.sat = 1'b0;
                if (q > longint'(sfir_pkg::SAMPLE_MAX)) begin
                    q = longint'(sfir_pkg::SAMPLE_MAX);
                    w.sat = 1'b1;
                end else if (q < longint'(sfir_pkg::SAMPLE_MIN)) begin
                    q = longint'(sfir_pkg::SAMPLE_MIN);
                    w.sat = 1'b1;
                end
                w.smp = sfir_pkg::SAMPLE_W'(q);
                w.last = w_last;
                filtered_q.push_back(w);
                wr_pos = pos + 1'b1;
            end
        endcase
    endfunction

    task automatic send_word(input logic [sfir_pkg::OP_W-1:0] w_op,
                             input logic signed [sfir_pkg::SAMPLE_W-1:0] w_smp,
                             input logic [sfir_pkg::CIDX_W-1:0] w_idx,
                             input logic signed [sfir_pkg::COEF_W-1:0] w_cv,
                             input logic [sfir_pkg::REWIND_W-1:0] w_rw,
                             input logic w_last);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= w_op;
        sample_in     <= w_smp;
        coef_index    <= w_idx;
        coef_value    <= w_cv;
        rewind_count  <= w_rw;
        block_last_in <= w_last;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        fir_apply(w_op, w_smp, w_idx, w_cv, w_rw, w_last);
    endtask

    task automatic send_sample(input logic signed [sfir_pkg::SAMPLE_W-1:0] w_smp,
                               input logic w_last);
        send_word(sfir_pkg::OP_FILT, w_smp, '0, '0, '0, w_last);
    endtask

    task automatic write_coef(input logic [sfir_pkg::CIDX_W-1:0] w_idx,
                              input logic signed [sfir_pkg::COEF_W-1:0] w_cv);
        send_word(sfir_pkg::OP_WCOEF, '0, w_idx, w_cv, '0, 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic set_taps(input logic [sfir_pkg::LEN_W-1:0] taps);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= taps;
        @(posedge clk);
        cfg_we  <= 1'b0;
        tap_len = taps;
    endtask

    // Output side: random stall per word, long hold on request, field compare.
    initial begin
        int         stall_left;
        int         hold_seen;
        t_filt_word w;
        stall_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t unexpected word: sample_out %0d", $time, sample_out);
                    errors++;
                end else begin
                    w = filtered_q.pop_front();
                    if (sample_out !== w.smp) begin
                        $display("%0t sample_out: expected %0d, actual %0d",
                                 $time, w.smp, sample_out);
                        errors++;
                    end
                    if (saturated !== w.sat) begin
                        $display("%0t saturated: expected %0b, actual %0b",
                                 $time, w.sat, saturated);
                        errors++;
                    end
                    if (block_last_out !== w.last) begin
                        $display("%0t block_last_out: expected %0b, actual %0b",
                                 $time, w.last, block_last_out);
                        errors++;
                    end
                end
                stall_left = draw_gap(rx_burst);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic test_coef_load();
        for (int i = 0; i < sfir_pkg::COEF_DEPTH; i++) begin
            write_coef(sfir_pkg::CIDX_W'(i), sfir_pkg::COEF_W'($urandom));
        end
        settle();
    endtask

    // Zero length runs as center tap only.
    task automatic test_center_only();
        set_taps(8'd0);
        write_coef(7'd0, sfir_pkg::COEF_W'(-131072));
        send_sample(sfir_pkg::SAMPLE_MAX, 1'b1);
        send_sample(sfir_pkg::SAMPLE_MIN, 1'b0);
        write_coef(7'd0, sfir_pkg::COEF_W'(131071));
        send_sample(sfir_pkg::SAMPLE_MAX, 1'b0);
        send_sample(sfir_pkg::SAMPLE_MIN, 1'b1);
        settle();
    endtask

    task automatic test_saturation();
        set_taps(8'd3);
        write_coef(7'd0, sfir_pkg::COEF_W'(131071));
        write_coef(7'd1, sfir_pkg::COEF_W'(131071));
        repeat (3) send_sample(sfir_pkg::SAMPLE_MAX, 1'b0);
        repeat (3) send_sample(sfir_pkg::SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b0);
        settle();
    endtask

    // Even length leaves one sample out of the sum.
    task automatic test_even_length();
        set_taps(8'd4);
        write_coef(7'd0, sfir_pkg::COEF_W'(-4096));
        write_coef(7'd1, sfir_pkg::COEF_W'(65536));
        send_sample(sfir_pkg::SAMPLE_W'(1000000), 1'b0);
        send_sample(sfir_pkg::SAMPLE_W'(-2000000), 1'b0);
        send_sample(sfir_pkg::SAMPLE_W'(3000000), 1'b0);
        send_sample(sfir_pkg::SAMPLE_W'(-4000000), 1'b1);
        settle();
    endtask

    // Rewind wraps around the delay line in both directions; clear resets position.
    task automatic test_rewind_clear();
        set_taps(8'd5);
        send_word(sfir_pkg::OP_REWIND, '0, '0, '0, 8'd255, 1'b0);
        send_sample(sfir_pkg::SAMPLE_W'(12345), 1'b0);
        send_word(sfir_pkg::OP_REWIND, '0, '0, '0, 8'd0, 1'b0);
        send_sample(sfir_pkg::SAMPLE_W'(-54321), 1'b0);
        send_word(sfir_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b0);
        send_word(sfir_pkg::OP_REWIND, '0, '0, '0, 8'd1, 1'b0);
        send_sample(sfir_pkg::SAMPLE_W'(777), 1'b1);
        settle();
    endtask

    task automatic test_max_length();
        set_taps(8'd255);
        repeat (4) send_sample(sfir_pkg::SAMPLE_W'($urandom), 1'b0);
        set_taps(8'd254);
        repeat (2) send_sample(sfir_pkg::SAMPLE_W'($urandom), 1'b1);
        settle();
    endtask

    // Output held off for a long stretch while input keeps coming.
    task automatic test_backpressure();
        set_taps(8'd15);
        tx_burst = 1'b1;
        hold_req <= hold_req + 1;
        repeat (12) send_sample(sfir_pkg::SAMPLE_W'($urandom), 1'($urandom));
        tx_burst = 1'b0;
        settle();
    endtask

    task automatic test_random();
        int                                   sent;
        int                                   n;
        int                                   r;
        logic [sfir_pkg::LEN_W-1:0]           taps;
        logic [sfir_pkg::OP_W-1:0]            w_op;
        logic signed [sfir_pkg::SAMPLE_W-1:0] w_smp;
        logic signed [sfir_pkg::COEF_W-1:0]   w_cv;
        sent = 0;
        while (sent < RAND_WORDS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                taps = sfir_pkg::LEN_W'($urandom_range(200, 255));
                n = 6;
            end else if (r == 1) begin
                taps = '0;
                n = 20;
            end else begin
                taps = sfir_pkg::LEN_W'($urandom_range(1, 33));
                n = $urandom_range(20, 60);
            end
            set_taps(taps);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 72) w_op = sfir_pkg::OP_FILT;
                else if (r < 88) w_op = sfir_pkg::OP_WCOEF;
                else if (r < 92) w_op = sfir_pkg::OP_CLEAR;
                else w_op = sfir_pkg::OP_REWIND;
                r = $urandom_range(0, 9);
                if (r == 0) w_smp = sfir_pkg::SAMPLE_MAX;
                else if (r == 1) w_smp = sfir_pkg::SAMPLE_MIN;
                else w_smp = sfir_pkg::SAMPLE_W'($urandom);
                if ($urandom_range(0, 1) == 0) w_cv = sfir_pkg::COEF_W'($urandom);
                else w_cv = sfir_pkg::COEF_W'($urandom_range(0, 4095)) -
                            sfir_pkg::COEF_W'(2048);
                send_word(w_op, w_smp, sfir_pkg::CIDX_W'($urandom), w_cv,
                          sfir_pkg::REWIND_W'($urandom), 1'($urandom));
                sent++;
            end
            tx_burst = 1'b0;
            rx_burst = 1'b0;
        end
        settle();
    endtask

    initial begin
        foreach (dline[i]) dline[i] = '0;
        foreach (coef_mem[i]) coef_mem[i] = '0;
        wr_pos = '0;
        tap_len = sfir_pkg::LEN_W'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_coef_load();
        test_center_only();
        test_saturation();
        test_even_length();
        test_rewind_clear();
        test_max_length();
        test_backpressure();
        test_random();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
